FILE: design/i2rd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2rd_pkg: shared types and constants for the radix digit converter
// Holds control/status bundles, FSM states, register map and symbol helpers.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned MaxRadix      = 16;
  localparam int unsigned RadixW        = 5;
  localparam int unsigned SymW          = 8;
  localparam int unsigned NumSyms       = 16;
  localparam int unsigned TableW        = NumSyms * SymW;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned CfgAddrW      = 5;

  localparam logic [SymW-1:0] CharCtrlMax = 8'd31;
  localparam logic [SymW-1:0] CharPlus    = 8'd43;
  localparam logic [SymW-1:0] CharMinus   = 8'd45;
  localparam logic [SymW-1:0] CharDel     = 8'd127;

  typedef enum logic [1:0] {
    RegRadix      = 2'd0,
    RegDigitsLow  = 2'd1,
    RegDigitsHigh = 2'd2,
    RegNone       = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StSign,
    StDivSet,
    StDiv,
    StStore,
    StTest,
    StRead,
    StSend
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic minus_load;
    logic div_clear;
    logic div_step;
    logic digit_store;
    logic rd_issue;
    logic sym_load;
  } i2rd_cmd_t;

  typedef struct packed {
    logic neg;
    logic table_valid;
    logic div_done;
    logic more_digits;
    logic last_digit;
    logic out_free;
  } i2rd_status_t;

  // Pick the symbol byte for one digit value.
  function automatic logic [SymW-1:0] symbol_of(logic [TableW-1:0] tbl,
                                                logic [DigitW-1:0] d);
    symbol_of = tbl[SymW*d +: SymW];
  endfunction

  // Table is usable only with a sane base and distinct printable symbols.
  function automatic logic table_ok(logic [RadixW-1:0] radix,
                                    logic [TableW-1:0] tbl);
    logic            ok;
    logic [SymW-1:0] c;
    ok = (radix >= RadixW'(2)) && (radix <= RadixW'(MaxRadix));
    for (int i = 0; i < NumSyms; i++) begin
      c = tbl[SymW*i +: SymW];
      if (RadixW'(i) < radix) begin
        if (c <= CharCtrlMax || c == CharPlus || c == CharMinus || c == CharDel) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < NumSyms; j++) begin
          if (RadixW'(j) < radix && tbl[SymW*j +: SymW] == c) begin
            ok = 1'b0;
          end
        end
      end
    end
    table_ok = ok;
  endfunction

endpackage
`default_nettype wire

FILE: design/i2rd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2rd_ram: generic single-port-write, registered-read RAM
// One write and one read address per cycle; read data held until next read.
// ----------------------------------------------------------------------------
module i2rd_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: design/i2rd_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2rd_dpath: magnitude, bit-serial divider, digit store and output register
// Runs one restoring-division step per cycle under controller commands.
// ----------------------------------------------------------------------------
module i2rd_dpath #(
  parameter int unsigned ValueWidth = i2rd_pkg::DefValueWidth
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire [ValueWidth-1:0]              value_i,
  input  wire [i2rd_pkg::RadixW-1:0]        radix_i,
  input  wire [i2rd_pkg::TableW-1:0]        table_i,
  input  i2rd_pkg::i2rd_cmd_t               cmd_i,
  output i2rd_pkg::i2rd_status_t            status_o,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [i2rd_pkg::SymW-1:0]         symbol_o,
  output logic                              last_o
);

  localparam int unsigned AddrW = $clog2(ValueWidth);
  localparam int unsigned CntW  = $clog2(ValueWidth + 1);

  logic                         neg_q;
  logic                         valid_q;
  logic [ValueWidth-1:0]        quo_q;
  logic [i2rd_pkg::DigitW-1:0]  rem_q;
  logic [AddrW-1:0]             bit_cnt_q;
  logic [CntW-1:0]              cnt_q;
  logic                         out_valid_q;
  logic [i2rd_pkg::SymW-1:0]    sym_q;
  logic                         last_q;

  logic [i2rd_pkg::RadixW-1:0]  trial;
  logic [i2rd_pkg::RadixW-1:0]  diff;
  logic                         qbit;
  logic [i2rd_pkg::DigitW-1:0]  rd_digit;
  logic [CntW-1:0]              rd_idx;

  // Shift next dividend bit into the partial remainder, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[ValueWidth-1]};
    diff  = trial - radix_i;
    qbit  = (trial >= radix_i);
  end

  assign rd_idx = cnt_q - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q     <= 1'b0;
      valid_q   <= 1'b0;
      quo_q     <= '0;
      rem_q     <= '0;
      bit_cnt_q <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.capture) begin
        neg_q <= value_i[ValueWidth-1];
        quo_q <= value_i[ValueWidth-1] ? (~value_i + ValueWidth'(1)) : value_i;
        cnt_q <= '0;
      end
      if (cmd_i.check) begin
        valid_q <= i2rd_pkg::table_ok(radix_i, table_i);
      end
      if (cmd_i.div_clear) begin
        rem_q     <= '0;
        bit_cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        rem_q     <= qbit ? diff[i2rd_pkg::DigitW-1:0] : trial[i2rd_pkg::DigitW-1:0];
        quo_q     <= {quo_q[ValueWidth-2:0], qbit};
        bit_cnt_q <= bit_cnt_q + AddrW'(1);
      end
      if (cmd_i.digit_store) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.sym_load) begin
        cnt_q <= rd_idx;
      end
    end
  end

  i2rd_ram #(
    .Width (i2rd_pkg::DigitW),
    .Depth (ValueWidth)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.digit_store),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (rem_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx[AddrW-1:0]),
    .rdata_o (rd_digit)
  );

  // Output register: hold the character until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.minus_load || cmd_i.sym_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.minus_load) begin
      sym_q  <= i2rd_pkg::CharMinus;
      last_q <= ~valid_q;
    end else if (cmd_i.sym_load) begin
      sym_q  <= i2rd_pkg::symbol_of(table_i, rd_digit);
      last_q <= (cnt_q == CntW'(1));
    end
  end

  assign status_o.neg         = neg_q;
  assign status_o.table_valid = valid_q;
  assign status_o.div_done    = (bit_cnt_q == AddrW'(ValueWidth - 1));
  assign status_o.more_digits = (quo_q != '0) && (cnt_q != CntW'(ValueWidth));
  assign status_o.last_digit  = (cnt_q == CntW'(1));
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

FILE: design/i2rd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2rd_ctrl: conversion sequencer
// Steps through capture, table check, sign, per-digit division and digit emission.
// ----------------------------------------------------------------------------
module i2rd_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  i2rd_pkg::i2rd_status_t  status_i,
  output i2rd_pkg::i2rd_cmd_t     cmd_o
);

  i2rd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2rd_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      i2rd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = i2rd_pkg::StCheck;
        end
      end
      i2rd_pkg::StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = i2rd_pkg::StSign;
      end
      i2rd_pkg::StSign: begin
        if (status_i.neg) begin
          if (status_i.out_free) begin
            cmd_o.minus_load = 1'b1;
            state_d = status_i.table_valid ? i2rd_pkg::StDivSet : i2rd_pkg::StIdle;
          end
        end else begin
          state_d = status_i.table_valid ? i2rd_pkg::StDivSet : i2rd_pkg::StIdle;
        end
      end
      i2rd_pkg::StDivSet: begin
        cmd_o.div_clear = 1'b1;
        state_d         = i2rd_pkg::StDiv;
      end
      i2rd_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = i2rd_pkg::StStore;
        end
      end
      i2rd_pkg::StStore: begin
        cmd_o.digit_store = 1'b1;
        state_d           = i2rd_pkg::StTest;
      end
      i2rd_pkg::StTest: begin
        state_d = status_i.more_digits ? i2rd_pkg::StDivSet : i2rd_pkg::StRead;
      end
      i2rd_pkg::StRead: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = i2rd_pkg::StSend;
      end
      i2rd_pkg::StSend: begin
        if (status_i.out_free) begin
          cmd_o.sym_load = 1'b1;
          state_d = status_i.last_digit ? i2rd_pkg::StIdle : i2rd_pkg::StRead;
        end
      end
      default: begin
        state_d = i2rd_pkg::StIdle;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/integer_to_radix_digits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to text in a configurable base
// One value in on the slave stream, its characters out on the master stream.
// ----------------------------------------------------------------------------
// Usage:
//   Program radix (byte 0x00) and the 16-entry symbol table (0x08 low half,
//   0x10 high half) over the APB port while no conversion is in flight.
//   Push one two's-complement value on s_axis; the block answers with its
//   characters on m_axis, most significant digit first, tlast on the final
//   one. A negative value starts with '-'. With an unusable table only the
//   '-' of a negative value comes out (with tlast), else nothing.
// Operation:
//   Each digit runs the bit-serial divider (one quotient bit per cycle),
//   then is stored to digit RAM; each character is a digit-RAM read and a
//   load into the output register. Capture and table check come first.
//   One value is worked on at a time; s_axis_tready is high only between
//   conversions.
// Reset and stall:
//   Reset clears sequencer and state; symbol byte and digit RAM need no clear.
//   The last character sits in the output register while the next value is
//   taken; a stalled m_axis_tready holds the sequencer before the next load.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int unsigned VALUE_WIDTH = i2rd_pkg::DefValueWidth
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // value[VALUE_WIDTH-1:0], zero padded to whole bytes
  input  wire  [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // symbol[7:0]
  output logic [i2rd_pkg::SymW-1:0]            m_axis_tdata,
  output logic                                 m_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [i2rd_pkg::CfgAddrW-1:0]        paddr,
  input  wire  [i2rd_pkg::CfgDataW-1:0]        pwdata,
  output logic [i2rd_pkg::CfgDataW-1:0]        prdata,
  output logic                                 pready
);

  logic [i2rd_pkg::RadixW-1:0]   radix_q;
  logic [i2rd_pkg::CfgDataW-1:0] digits_low_q;
  logic [i2rd_pkg::CfgDataW-1:0] digits_high_q;
  i2rd_pkg::reg_idx_e            reg_idx;
  logic                          cfg_wr;

  i2rd_pkg::i2rd_cmd_t           cmd;
  i2rd_pkg::i2rd_status_t        status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  // Registers sit on 8-byte boundaries; the low address bits are ignored.
  assign reg_idx = i2rd_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q       <= '0;
      digits_low_q  <= '0;
      digits_high_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        i2rd_pkg::RegRadix:      radix_q       <= pwdata[i2rd_pkg::RadixW-1:0];
        i2rd_pkg::RegDigitsLow:  digits_low_q  <= pwdata;
        i2rd_pkg::RegDigitsHigh: digits_high_q <= pwdata;
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      i2rd_pkg::RegRadix:      prdata = {{(i2rd_pkg::CfgDataW - i2rd_pkg::RadixW){1'b0}},
                                         radix_q};
      i2rd_pkg::RegDigitsLow:  prdata = digits_low_q;
      i2rd_pkg::RegDigitsHigh: prdata = digits_high_q;
      default:                 prdata = '0;
    endcase
  end

  i2rd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2rd_dpath #(
    .ValueWidth (VALUE_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata[VALUE_WIDTH-1:0]),
    .radix_i     (radix_q),
    .table_i     ({digits_high_q, digits_low_q}),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .symbol_o    (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule
`default_nettype wire
